### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("checker assertion failed");

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("checker assertion failed");

`endif

### design/lclip_pkg.sv
package lclip_pkg;

  // Field widths.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS = 16;

  // Quotient bits resolved per divider stage.
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = FRAC_BITS / DIV_BITS_PER_STAGE;

  // Pipeline stage numbers.
  localparam int unsigned STG_FRONT = 0;
  localparam int unsigned STG_SEL_MUL = 1;
  localparam int unsigned STG_SEL = 2;
  localparam int unsigned STG_CMP_MUL = 3;
  localparam int unsigned STG_CMP = 4;
  localparam int unsigned STG_DIV_FIRST = 5;
  localparam int unsigned STG_DIV_LAST = STG_DIV_FIRST + DIV_STAGES - 1;
  localparam int unsigned STG_ROUND = STG_DIV_LAST + 1;
  localparam int unsigned STG_SCALE = STG_ROUND + 1;
  localparam int unsigned STG_OUT = STG_SCALE + 1;
  localparam int unsigned NUM_STAGES = STG_OUT + 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0] mag_t;
  typedef logic [2*COORD_BITS-1:0] prod_t;
  typedef logic [FRAC_BITS:0] q_t;
  typedef logic [FRAC_BITS+COORD_BITS:0] scl_t;

  localparam coord_t LEFT_RESET = coord_t'(0);
  localparam coord_t RIGHT_RESET = coord_t'(639);
  localparam coord_t BOTTOM_RESET = coord_t'(0);
  localparam coord_t TOP_RESET = coord_t'(479);

  localparam q_t Q_ONE = q_t'(1) << FRAC_BITS;
  localparam scl_t SCL_HALF = scl_t'(1) << (FRAC_BITS - 1);

  // Per-axis result of the front stage.
  typedef struct packed {
    logic rej;
    logic neg;
    mag_t m;
    mag_t en;
    mag_t ed;
    mag_t ln;
    mag_t ld;
  } axis_t;

  // Everything that travels down the pipeline.
  typedef struct packed {
    logic ok;
    logic smov;
    logic emov;
    logic fe;
    logic fl;
    coord_t x1;
    coord_t y1;
    mag_t adx;
    mag_t ady;
    logic nx;
    logic ny;
    mag_t exn;
    mag_t exd;
    mag_t eyn;
    mag_t eyd;
    mag_t lxn;
    mag_t lxd;
    mag_t lyn;
    mag_t lyd;
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
    mag_t re;
    mag_t rl;
    q_t qe;
    q_t ql;
    scl_t m0;
    scl_t m1;
    scl_t m2;
    scl_t m3;
    coord_t cx0;
    coord_t cy0;
    coord_t cx1;
    coord_t cy1;
  } st_t;

endpackage

### design/line_clip_liang_barsky.sv
// Liang-Barsky line clipper, one segment per transaction.
// Throughput: one segment per cycle; the pipeline advances as a whole whenever
// the output register is empty or its transaction is taken.
// Reset (rst, synchronous) empties the pipeline and loads the window
// registers with left 0, right 639, bottom 0, top 479.
module line_clip_liang_barsky (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lclip_pkg::coord_t         start_x,
  input  lclip_pkg::coord_t         start_y,
  input  lclip_pkg::coord_t         end_x,
  input  lclip_pkg::coord_t         end_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      visible,
  output lclip_pkg::coord_t         clip_start_x,
  output lclip_pkg::coord_t         clip_start_y,
  output lclip_pkg::coord_t         clip_end_x,
  output lclip_pkg::coord_t         clip_end_y,
  output logic                      start_moved,
  output logic                      end_moved,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  lclip_pkg::reg_idx_t       cfg_index,
  input  lclip_pkg::coord_t         cfg_data
);
  import lclip_pkg::*;

  coord_t window_left;
  coord_t window_right;
  coord_t window_bottom;
  coord_t window_top;

  st_t pipe [NUM_STAGES];
  st_t pipe_next [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld;
  logic adv;

  // Candidate entry and exit fractions along one axis, clamped to [0,1].
  function automatic axis_t axis(input coord_t a, input coord_t b,
                                 input coord_t lo, input coord_t hi);
    logic signed [COORD_BITS:0] ae;
    logic signed [COORD_BITS:0] be;
    logic signed [COORD_BITS:0] loe;
    logic signed [COORD_BITS:0] hie;
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] e;
    logic signed [COORD_BITS:0] l;
    logic signed [COORD_BITS:0] ms;
    axis_t r;
    ae = {a[COORD_BITS-1], a};
    be = {b[COORD_BITS-1], b};
    loe = {lo[COORD_BITS-1], lo};
    hie = {hi[COORD_BITS-1], hi};
    d = be - ae;
    r.neg = d[COORD_BITS];
    r.m = r.neg ? mag_t'(-d) : mag_t'(d);
    ms = $signed({1'b0, r.m});
    if (d == '0) begin
      r.rej = (a < lo) || (a > hi);
      r.en = '0;
      r.ed = mag_t'(1);
      r.ln = mag_t'(1);
      r.ld = mag_t'(1);
    end else begin
      if (!r.neg) begin
        e = loe - ae;
        l = hie - ae;
      end else begin
        e = ae - hie;
        l = ae - loe;
      end
      r.rej = (e > ms) || (l < 0);
      if (e <= 0) begin
        r.en = '0;
        r.ed = mag_t'(1);
      end else begin
        r.en = mag_t'(e);
        r.ed = r.m;
      end
      if (l >= ms) begin
        r.ln = mag_t'(1);
        r.ld = mag_t'(1);
      end else begin
        r.ln = mag_t'(l);
        r.ld = r.m;
      end
    end
    return r;
  endfunction

  // Work of the first stage, straight from the input ports.
  function automatic st_t front(input coord_t x1, input coord_t y1,
                                input coord_t x2, input coord_t y2,
                                input coord_t wl, input coord_t wr,
                                input coord_t wb, input coord_t wt);
    axis_t ax;
    axis_t ay;
    st_t r;
    ax = axis(x1, x2, wl, wr);
    ay = axis(y1, y2, wb, wt);
    r = '0;
    r.ok = !(ax.rej || ay.rej);
    r.x1 = x1;
    r.y1 = y1;
    r.adx = ax.m;
    r.ady = ay.m;
    r.nx = ax.neg;
    r.ny = ay.neg;
    r.exn = ax.en;
    r.exd = ax.ed;
    r.eyn = ay.en;
    r.eyd = ay.ed;
    r.lxn = ax.ln;
    r.lxd = ax.ld;
    r.lyn = ay.ln;
    r.lyd = ay.ld;
    return r;
  endfunction

  // Stage k's work on the transaction held by stage k-1.
  function automatic st_t advance(input int unsigned k, input st_t a);
    st_t r;
    logic [COORD_BITS:0] r2;
    scl_t o0;
    scl_t o1;
    scl_t o2;
    scl_t o3;
    mag_t f0;
    mag_t f1;
    mag_t f2;
    mag_t f3;
    r = a;
    case (k) inside
      STG_SEL_MUL: begin
        r.p0 = prod_t'(a.exn) * prod_t'(a.eyd);
        r.p1 = prod_t'(a.eyn) * prod_t'(a.exd);
        r.p2 = prod_t'(a.lxn) * prod_t'(a.lyd);
        r.p3 = prod_t'(a.lyn) * prod_t'(a.lxd);
      end
      STG_SEL: begin
        // Latest entry and earliest exit over both axes.
        if (a.p1 > a.p0) begin
          r.exn = a.eyn;
          r.exd = a.eyd;
        end
        if (a.p3 < a.p2) begin
          r.lxn = a.lyn;
          r.lxd = a.lyd;
        end
      end
      STG_CMP_MUL: begin
        r.p0 = prod_t'(a.exn) * prod_t'(a.lxd);
        r.p1 = prod_t'(a.lxn) * prod_t'(a.exd);
      end
      STG_CMP: begin
        // Reject when the entry lies beyond the exit; set up the dividers.
        r.ok = a.ok && !(a.p0 > a.p1);
        r.smov = (a.exn != '0);
        r.emov = (a.lxn != a.lxd);
        r.fe = (a.exn >= a.exd);
        r.fl = (a.lxn >= a.lxd);
        r.re = a.exn;
        r.rl = a.lxn;
        r.qe = '0;
        r.ql = '0;
      end
      [STG_DIV_FIRST:STG_DIV_LAST]: begin
        // Restoring division, a fixed number of quotient bits per stage.
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
          r2 = {r.re, 1'b0};
          if (r2 >= {1'b0, r.exd}) begin
            r.re = mag_t'(r2 - {1'b0, r.exd});
            r.qe = {r.qe[FRAC_BITS-1:0], 1'b1};
          end else begin
            r.re = mag_t'(r2);
            r.qe = {r.qe[FRAC_BITS-1:0], 1'b0};
          end
          r2 = {r.rl, 1'b0};
          if (r2 >= {1'b0, r.lxd}) begin
            r.rl = mag_t'(r2 - {1'b0, r.lxd});
            r.ql = {r.ql[FRAC_BITS-1:0], 1'b1};
          end else begin
            r.rl = mag_t'(r2);
            r.ql = {r.ql[FRAC_BITS-1:0], 1'b0};
          end
        end
      end
      STG_ROUND: begin
        // Round the quotients to nearest, ties up; a full fraction is one.
        r2 = {a.re, 1'b0};
        if (a.fe) begin
          r.qe = Q_ONE;
        end else begin
          r.qe = a.qe + q_t'(r2 >= {1'b0, a.exd});
        end
        r2 = {a.rl, 1'b0};
        if (a.fl) begin
          r.ql = Q_ONE;
        end else begin
          r.ql = a.ql + q_t'(r2 >= {1'b0, a.lxd});
        end
      end
      STG_SCALE: begin
        r.m0 = scl_t'(a.qe) * scl_t'(a.adx);
        r.m1 = scl_t'(a.qe) * scl_t'(a.ady);
        r.m2 = scl_t'(a.ql) * scl_t'(a.adx);
        r.m3 = scl_t'(a.ql) * scl_t'(a.ady);
      end
      STG_OUT: begin
        // Rounded offsets applied toward the far endpoint.
        o0 = (a.m0 + SCL_HALF) >> FRAC_BITS;
        o1 = (a.m1 + SCL_HALF) >> FRAC_BITS;
        o2 = (a.m2 + SCL_HALF) >> FRAC_BITS;
        o3 = (a.m3 + SCL_HALF) >> FRAC_BITS;
        f0 = o0[COORD_BITS-1:0];
        f1 = o1[COORD_BITS-1:0];
        f2 = o2[COORD_BITS-1:0];
        f3 = o3[COORD_BITS-1:0];
        if (a.ok) begin
          r.cx0 = a.nx ? coord_t'(a.x1 - f0) : coord_t'(a.x1 + f0);
          r.cy0 = a.ny ? coord_t'(a.y1 - f1) : coord_t'(a.y1 + f1);
          r.cx1 = a.nx ? coord_t'(a.x1 - f2) : coord_t'(a.x1 + f2);
          r.cy1 = a.ny ? coord_t'(a.y1 - f3) : coord_t'(a.y1 + f3);
        end else begin
          r.cx0 = '0;
          r.cy0 = '0;
          r.cx1 = '0;
          r.cy1 = '0;
          r.smov = 1'b0;
          r.emov = 1'b0;
        end
      end
      default: begin
        r = a;
      end
    endcase
    return r;
  endfunction

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left <= LEFT_RESET;
      window_right <= RIGHT_RESET;
      window_bottom <= BOTTOM_RESET;
      window_top <= TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT: window_left <= cfg_data;
        REG_RIGHT: window_right <= cfg_data;
        REG_BOTTOM: window_bottom <= cfg_data;
        REG_TOP: window_top <= cfg_data;
        default: window_left <= window_left;
      endcase
    end
  end

  // The whole pipeline moves unless a finished transaction is held at the output.
  assign adv = !(vld[NUM_STAGES-1] && out_stall);
  assign in_stall = !adv;

  assign pipe_next[STG_FRONT] = front(start_x, start_y, end_x, end_y,
                                      window_left, window_right,
                                      window_bottom, window_top);

  for (genvar g = 1; g < NUM_STAGES; g++) begin : g_stage
    assign pipe_next[g] = advance(g, pipe[g-1]);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        pipe[i] <= pipe_next[i];
      end
    end
  end

  // Output register is the last stage.
  assign out_valid = vld[NUM_STAGES-1];
  assign visible = pipe[STG_OUT].ok;
  assign clip_start_x = pipe[STG_OUT].cx0;
  assign clip_start_y = pipe[STG_OUT].cy0;
  assign clip_end_x = pipe[STG_OUT].cx1;
  assign clip_end_y = pipe[STG_OUT].cy1;
  assign start_moved = pipe[STG_OUT].smov;
  assign end_moved = pipe[STG_OUT].emov;

endmodule

### design/lclip_checker.sv
`include "assert_macros.svh"

module lclip_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input lclip_pkg::coord_t   start_x,
  input lclip_pkg::coord_t   start_y,
  input lclip_pkg::coord_t   end_x,
  input lclip_pkg::coord_t   end_y,
  input logic                out_valid,
  input logic                out_stall,
  input logic                visible,
  input lclip_pkg::coord_t   clip_start_x,
  input lclip_pkg::coord_t   clip_start_y,
  input lclip_pkg::coord_t   clip_end_x,
  input lclip_pkg::coord_t   clip_end_y,
  input logic                start_moved,
  input logic                end_moved,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input lclip_pkg::reg_idx_t cfg_index,
  input lclip_pkg::coord_t   cfg_data
);
  import lclip_pkg::*;

  // A stalled result stays in place.
  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(clip_start_x) && $stable(clip_end_y) && $stable(visible))

  // A rejected segment reports zeros throughout.
  `CHK_ASSERT(a_reject_zero, out_valid && !visible |-> clip_start_x == 0 && clip_start_y == 0 && clip_end_x == 0 && clip_end_y == 0 && !start_moved && !end_moved)

  // A held result blocks the input side.
  `CHK_ASSERT(a_stall_back, out_valid && out_stall |-> in_stall)

  // Reset leaves nothing on the output.
  `CHK_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind line_clip_liang_barsky lclip_checker u_lclip_checker (.*);

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lclip_pkg::*;

  // One segment as presented on the input channel.
  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  // One clip result as seen on the output channel.
  typedef struct {
    logic   vis;
    coord_t csx;
    coord_t csy;
    coord_t cex;
    coord_t cey;
    logic   smov;
    logic   emov;
  } clipped_t;

  // Clip predictor with its own copy of the window, and the queue of pending results.
  class clip_scoreboard;
    coord_t   window[4];
    clipped_t pending_clips[$];
    int       errors;

    function new();
      window[REG_LEFT]   = LEFT_RESET;
      window[REG_RIGHT]  = RIGHT_RESET;
      window[REG_BOTTOM] = BOTTOM_RESET;
      window[REG_TOP]    = TOP_RESET;
      errors = 0;
    endfunction

    // Parameter u = n/d in [0,1], rounded to FRAC_BITS fraction bits, ties up.
    function longint quantize_u(longint n, longint d);
      longint t;
      if (n >= d) return longint'(1) << FRAC_BITS;
      t = (n << (FRAC_BITS + 1)) / d;
      return (t + 1) >>> 1;
    endfunction

    // Point at parameter u along one axis, offset rounded half away from zero.
    function coord_t lerp_axis(longint base, longint d, longint u);
      longint off;
      off = (u * (d < 0 ? -d : d) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return coord_t'(d < 0 ? base - off : base + off);
    endfunction

    // Work out the expected clip of an accepted segment.
    function void note_segment(segment_t s);
      longint x1, y1, dx, dy, n, d;
      longint p[4], q[4];
      longint en_n, en_d, lv_n, lv_d, ue, ux;
      logic ok;
      clipped_t r;
      x1 = s.sx;
      y1 = s.sy;
      dx = longint'(s.ex) - x1;
      dy = longint'(s.ey) - y1;
      p[0] = -dx; q[0] = x1 - longint'(window[REG_LEFT]);
      p[1] = dx;  q[1] = longint'(window[REG_RIGHT]) - x1;
      p[2] = -dy; q[2] = y1 - longint'(window[REG_BOTTOM]);
      p[3] = dy;  q[3] = longint'(window[REG_TOP]) - y1;
      en_n = 0; en_d = 1; lv_n = 1; lv_d = 1;
      ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (p[i] == 0) begin
          if (q[i] < 0) ok = 1'b0;
        end else if (p[i] < 0) begin
          n = -q[i]; d = -p[i];
          if (n * en_d > en_n * d) begin
            en_n = n; en_d = d;
          end
        end else begin
          n = q[i]; d = p[i];
          if (n * lv_d < lv_n * d) begin
            lv_n = n; lv_d = d;
          end
        end
      end
      if (ok && en_n * lv_d > lv_n * en_d) ok = 1'b0;
      r = '{1'b0, '0, '0, '0, '0, 1'b0, 1'b0};
      if (ok) begin
        ue = quantize_u(en_n, en_d);
        ux = quantize_u(lv_n, lv_d);
        r.vis  = 1'b1;
        r.csx  = lerp_axis(x1, dx, ue);
        r.csy  = lerp_axis(y1, dy, ue);
        r.cex  = lerp_axis(x1, dx, ux);
        r.cey  = lerp_axis(y1, dy, ux);
        r.smov = en_n > 0;
        r.emov = lv_n < lv_d;
      end
      pending_clips.insert(pending_clips.size(), r);
    endfunction

    // Compare an accepted result with the oldest expectation.
    function void check_clip(clipped_t a);
      clipped_t e;
      if (pending_clips.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending_clips.pop_front();
      if (a.vis !== e.vis) begin
        $error("visible: expected %0d actual %0d", e.vis, a.vis); errors++;
      end
      if (a.csx !== e.csx) begin
        $error("clip_start_x: expected %0d actual %0d", e.csx, a.csx); errors++;
      end
      if (a.csy !== e.csy) begin
        $error("clip_start_y: expected %0d actual %0d", e.csy, a.csy); errors++;
      end
      if (a.cex !== e.cex) begin
        $error("clip_end_x: expected %0d actual %0d", e.cex, a.cex); errors++;
      end
      if (a.cey !== e.cey) begin
        $error("clip_end_y: expected %0d actual %0d", e.cey, a.cey); errors++;
      end
      if (a.smov !== e.smov) begin
        $error("start_moved: expected %0d actual %0d", e.smov, a.smov); errors++;
      end
      if (a.emov !== e.emov) begin
        $error("end_moved: expected %0d actual %0d", e.emov, a.emov); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic visible, start_moved, end_moved;
  coord_t clip_start_x, clip_start_y, clip_end_x, clip_end_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_LEFT;
  coord_t cfg_data = '0;

  clip_scoreboard sb = new();
  logic quiet = 1'b0;

  always #1 clk = ~clk;

  line_clip_liang_barsky dut (.*);

  // Note accepted segments and check accepted results.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_segment('{start_x, start_y, end_x, end_y});
    if (!rst && out_valid && !out_stall)
      sb.check_clip('{visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                      start_moved, end_moved});
  end

  // Receiver stalls in random bursts until the final part of the run.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one segment and hold it until the transaction completes.
  task automatic send_segment(int sx, int sy, int ex, int ey);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= coord_t'(sx);
    start_y  <= coord_t'(sy);
    end_x    <= coord_t'(ex);
    end_y    <= coord_t'(ey);
    do @(posedge clk); while (in_stall);
  endtask

  // Let the pipeline drain completely before touching the window.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_clips.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_valid after the last one.
  task automatic write_reg(reg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= coord_t'(value);
    do @(posedge clk); while (!cfg_ready);
    sb.window[idx] = coord_t'(value);
  endtask

  task automatic set_window(int l, int r, int b, int t);
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_TOP, t);
    cfg_valid <= 1'b0;
  endtask

  // Coordinate either anywhere in range or near the given window span.
  function automatic int pick_coord(int lo, int hi);
    int span;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535) - 32768;
    span = (hi > lo ? hi - lo : lo - hi) + 8;
    return (lo < hi ? lo : hi) - span / 4 + int'($urandom_range(0, span + span / 2));
  endfunction

  task automatic random_segments(int count);
    int l, r, b, t;
    l = sb.window[REG_LEFT];
    r = sb.window[REG_RIGHT];
    b = sb.window[REG_BOTTOM];
    t = sb.window[REG_TOP];
    repeat (count) begin
      int sx, sy;
      sx = pick_coord(l, r);
      sy = pick_coord(b, t);
      case ($urandom_range(0, 9))
        0: send_segment(sx, sy, sx, sy);
        1: send_segment(sx, sy, sx, pick_coord(b, t));
        2: send_segment(sx, sy, pick_coord(l, r), sy);
        default: send_segment(sx, sy, pick_coord(l, r), pick_coord(b, t));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed segments against the reset window.
    send_segment(10, 10, 100, 100);
    send_segment(-50, 240, 700, 240);
    send_segment(700, 240, -50, 240);
    send_segment(320, -100, 320, 600);
    send_segment(-100, -100, 800, 600);
    send_segment(-10, 500, 100, 700);
    send_segment(-5, 10, -5, 200);
    send_segment(10, 480, 300, 480);
    send_segment(0, 0, 639, 479);
    send_segment(100, 100, 100, 100);
    send_segment(-1, 100, -1, 100);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 0, 32767, 0);
    send_segment(0, 0, 0, 0);
    send_segment(639, 479, 640, 480);
    send_segment(-1, 0, 2, 3);
    send_segment(-32768, 240, 32767, 241);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(-32768, -32768, -32768, -32768);
    random_segments(120);
    drain();

    // Whole coordinate range as the window.
    set_window(-32768, 32767, -32768, 32767);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768);
    random_segments(130);
    drain();

    // Empty window rejects everything.
    set_window(10, 5, 7, -7);
    send_segment(7, 0, 7, 0);
    random_segments(80);
    drain();

    // Tiny window around the origin, where rounding effects dominate.
    set_window(-3, 3, -2, 2);
    random_segments(150);
    drain();

    // Random window, final part with no idling on either side.
    set_window($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) + 1000,
               $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) + 1000);
    random_segments(100);
    quiet = 1'b1;
    random_segments(150);
    in_valid <= 1'b0;

    while (sb.pending_clips.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_clips.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/lclip_pkg.sv
design/line_clip_liang_barsky.sv
design/lclip_checker.sv
bench/testbench.sv
